>>> sv/bdy_pkg.sv
`default_nettype none

package bdy_pkg;

    localparam int ORD_W  = 5;
    localparam int ADDR_W = 16;
    localparam int REQ_W  = 17;
    localparam int HDR_W  = 8;
    localparam int TOT_W  = 18;
    localparam int WIDE_W = 25;

    localparam logic [HDR_W-1:0] HDR_RESET = 8'd24;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } st_t;

    typedef struct packed {
        st_t               status;
        logic [ADDR_W-1:0] addr;
        logic [ORD_W-1:0]  order;
    } res_t;

    // smallest k with 2^k >= total; zero and one both give 0
    function automatic logic [ORD_W-1:0] clog2_tot(input logic [TOT_W-1:0] total);
        logic [ORD_W-1:0] k;
        k = '0;
        for (int i = 0; i < TOT_W; i++)
        begin
            if (((TOT_W+1)'(1) << i) < {1'b0, total})
            begin
                k = ORD_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> sv/bdy_core.sv
`default_nettype none

module bdy_core
    import bdy_pkg::*;
#(
    parameter int MAX_ORDER = 16,
    parameter int MIN_ORDER = 5
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cmd_t              cmd,
    input  wire logic [REQ_W-1:0]  req_size,
    input  wire logic [ADDR_W-1:0] blk_addr,
    input  wire logic [HDR_W-1:0]  hdr,
    input  wire logic              res_taken,
    output logic                   idle,
    output logic                   res_valid,
    output res_t                   res
);

    localparam int LEVELS     = MAX_ORDER - MIN_ORDER + 1;
    localparam int NW         = LEVELS;
    localparam int SW         = LEVELS - 1;
    localparam int OW         = MAX_ORDER;
    localparam int NODE_COUNT = (1 << LEVELS) - 1;
    localparam int SLOT_COUNT = 1 << SW;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_SRCH_RD   = 10'b00_0000_0100,
        S_SRCH_CHK  = 10'b00_0000_1000,
        S_SPLIT     = 10'b00_0001_0000,
        S_FREE_RD   = 10'b00_0010_0000,
        S_FREE_CHK  = 10'b00_0100_0000,
        S_MERGE_RD  = 10'b00_1000_0000,
        S_MERGE_CHK = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    localparam logic [ORD_W-1:0] MAX_O = ORD_W'(MAX_ORDER);
    localparam logic [ORD_W-1:0] MIN_O = ORD_W'(MIN_ORDER);

    function automatic logic [NW-1:0] lvl_base(input logic [ORD_W-1:0] lvl);
        logic [NW:0] one_sh;
        one_sh = (NW+1)'(1) << lvl;
        return NW'(one_sh - 1'b1);
    endfunction

    function automatic logic [NW-1:0] node_at(input logic [ORD_W-1:0] k,
                                              input logic [NW-1:0] pos);
        return lvl_base(MAX_O - k) + pos;
    endfunction

    state_t              state_reg, state_next;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [ORD_W-1:0]    lvl_reg, lvl_next;
    logic [ORD_W-1:0]    j_reg, j_next;
    logic [NW-1:0]       node_reg, node_next;
    logic [NW-1:0]       clr_reg, clr_next;
    logic [OW-1:0]       off_reg, off_next;
    res_t                res_reg, res_next;

    logic                free_mem [NODE_COUNT];
    logic [ORD_W:0]      slot_mem [SLOT_COUNT];
    logic                fr_data_reg;
    logic [ORD_W:0]      sr_data_reg;

    logic                fw_en;
    logic [NW-1:0]       fw_addr;
    logic                fw_data;
    logic [NW-1:0]       fr_addr;
    logic                sw_en;
    logic [SW-1:0]       sw_addr;
    logic [ORD_W:0]      sw_data;
    logic [SW-1:0]       slot_cur;

    logic [TOT_W-1:0]    total;
    logic [ORD_W-1:0]    k_raw;
    logic [ORD_W-1:0]    k_req;
    logic [WIDE_W-1:0]   free_off;
    logic [NW-1:0]       pos_cur;
    logic [ORD_W-1:0]    j_dn;
    logic [ORD_W-1:0]    s_ord;

    assign total    = TOT_W'(req_size) + TOT_W'(hdr);
    assign k_raw    = clog2_tot(total);
    assign k_req    = (k_raw < MIN_O) ? MIN_O : k_raw;
    assign free_off = WIDE_W'(blk_addr) - WIDE_W'(hdr);
    assign slot_cur = SW'(off_reg >> MIN_ORDER);
    assign pos_cur  = NW'(off_reg >> k_reg);
    assign j_dn     = j_reg - 1'b1;
    assign s_ord    = sr_data_reg[ORD_W-1:0];

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        lvl_next   = lvl_reg;
        j_next     = j_reg;
        node_next  = node_reg;
        clr_next   = clr_reg;
        off_next   = off_reg;
        res_next   = res_reg;
        fw_en      = 1'b0;
        fw_addr    = node_reg;
        fw_data    = 1'b0;
        fr_addr    = node_reg;
        sw_en      = 1'b0;
        sw_addr    = slot_cur;
        sw_data    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                fw_en   = 1'b1;
                fw_addr = clr_reg;
                fw_data = (clr_reg == '0);
                if (clr_reg[NW-1] == 1'b0)
                begin
                    sw_en   = 1'b1;
                    sw_addr = clr_reg[SW-1:0];
                end
                if (clr_reg == NW'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_ALLOC)
                    begin
                        if (k_req > MAX_O)
                        begin
                            res_next   = '{status: ST_NOMEM, addr: '0, order: '0};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            k_next     = k_req;
                            lvl_next   = MAX_O - k_req;
                            node_next  = lvl_base(MAX_O - k_req);
                            state_next = S_SRCH_RD;
                        end
                    end
                    else
                    begin
                        if ((blk_addr < ADDR_W'(hdr)) || ((free_off >> MAX_ORDER) != '0) ||
                            (free_off[MIN_ORDER-1:0] != '0))
                        begin
                            res_next   = '{status: ST_BADFREE, addr: '0, order: '0};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            off_next   = free_off[OW-1:0];
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end
            S_SRCH_RD:
            begin
                fr_addr    = node_reg;
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (fr_data_reg)
                begin
                    fw_en      = 1'b1;
                    fw_addr    = node_reg;
                    fw_data    = 1'b0;
                    j_next     = MAX_O - lvl_reg;
                    off_next   = OW'(node_reg - lvl_base(lvl_reg)) << (MAX_O - lvl_reg);
                    state_next = S_SPLIT;
                end
                else if (node_reg == NW'({lvl_base(lvl_reg), 1'b0}))
                begin
                    if (lvl_reg == '0)
                    begin
                        res_next   = '{status: ST_NOMEM, addr: '0, order: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg - 1'b1;
                        node_next  = lvl_base(lvl_reg - 1'b1);
                        state_next = S_SRCH_RD;
                    end
                end
                else
                begin
                    node_next  = node_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_SPLIT:
            begin
                if (j_reg > k_reg)
                begin
                    fw_en   = 1'b1;
                    fw_addr = node_at(j_dn, NW'(off_reg >> j_dn) + 1'b1);
                    fw_data = 1'b1;
                    j_next  = j_dn;
                end
                else
                begin
                    sw_en      = 1'b1;
                    sw_data    = {1'b1, k_reg};
                    res_next   = '{status: ST_OK,
                                   addr: ADDR_W'(WIDE_W'(off_reg) + WIDE_W'(hdr)),
                                   order: k_reg};
                    state_next = S_DONE;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (!sr_data_reg[ORD_W] || (s_ord < MIN_O) || (s_ord > MAX_O))
                begin
                    res_next   = '{status: ST_BADFREE, addr: '0, order: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    sw_en      = 1'b1;
                    k_next     = s_ord;
                    state_next = S_MERGE_RD;
                end
            end
            S_MERGE_RD:
            begin
                if (k_reg < MAX_O)
                begin
                    fr_addr    = node_at(k_reg, pos_cur ^ NW'(1));
                    state_next = S_MERGE_CHK;
                end
                else
                begin
                    fw_en      = 1'b1;
                    fw_addr    = node_at(k_reg, pos_cur);
                    fw_data    = 1'b1;
                    res_next   = '{status: ST_OK, addr: '0, order: k_reg};
                    state_next = S_DONE;
                end
            end
            S_MERGE_CHK:
            begin
                fw_en = 1'b1;
                if (fr_data_reg)
                begin
                    fw_addr    = node_at(k_reg, pos_cur ^ NW'(1));
                    fw_data    = 1'b0;
                    k_next     = k_reg + 1'b1;
                    state_next = S_MERGE_RD;
                end
                else
                begin
                    fw_addr    = node_at(k_reg, pos_cur);
                    fw_data    = 1'b1;
                    res_next   = '{status: ST_OK, addr: '0, order: k_reg};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        lvl_reg  <= lvl_next;
        j_reg    <= j_next;
        node_reg <= node_next;
        off_reg  <= off_next;
        res_reg  <= res_next;
    end

    // free map and per-slot order store
    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            free_mem[fw_addr] <= fw_data;
        end
        fr_data_reg <= free_mem[fr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            slot_mem[sw_addr] <= sw_data;
        end
        sr_data_reg <= slot_mem[slot_cur];
    end

endmodule

`default_nettype wire

>>> sv/buddy_allocator.sv
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata: request_size, block_address; tuser: command
// m_axis   | out | m_axis_tvalid/tready   | tdata: result_address, block_order; tuser: status
// cfg      | in  | cfg_valid/cfg_ready    | cfg_data: header_bytes
// After reset the free map is cleared one node at a time; no item is taken until it is done.
// Allocate: free-map nodes are each read and then checked, scanning from the requested order up,
// then one split step per level and one step to record the block in the slot store.
// Free: the slot store is read and checked, then each merge level reads and checks the buddy node.
// One item at a time; a finished result waits in the output register while the next is taken.
`default_nettype none

module buddy_allocator
    import bdy_pkg::*;
#(
    parameter int MAX_ORDER = 16,
    parameter int MIN_ORDER = 5
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // request_size[16:0], block_address[32:17]
    input  wire logic        s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // result_address[15:0], block_order[20:16]
    output logic [1:0]       m_axis_tuser,   // status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data        // header_bytes
);

    logic [HDR_W-1:0] hdr_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;
    logic             core_idle;
    logic             core_valid;
    res_t             core_res;
    logic             res_taken;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = core_idle;
    assign res_taken     = !out_valid_reg || m_axis_tready;

    bdy_core #(
        .MAX_ORDER (MAX_ORDER),
        .MIN_ORDER (MIN_ORDER)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && core_idle),
        .cmd       (cmd_t'(s_axis_tuser)),
        .req_size  (s_axis_tdata[16:0]),
        .blk_addr  (s_axis_tdata[32:17]),
        .hdr       (hdr_reg),
        .res_taken (res_taken),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= HDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                hdr_reg <= cfg_data;
            end
            if (core_valid && res_taken)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && res_taken)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.order, out_res_reg.addr};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire

>>> sv/bdy_check.sv
`default_nettype none

module bdy_check
    import bdy_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NOMEM ||
                           m_axis_tuser == ST_BADFREE))
        else $error("unknown status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("failed item carries data");

    a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OK |-> m_axis_tdata[20:16] != '0)
        else $error("ok item with zero order");

endmodule

bind buddy_allocator bdy_check u_bdy_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> test/buddy_checker.sv
`timescale 1ns / 1ps

module buddy_checker
    import bdy_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,
    output int               errors,
    output int               pending
);
    localparam int MAXO = 16;
    localparam int MINO = 5;
    localparam int NODES = (1 << (MAXO - MINO + 1)) - 1;
    localparam int SLOTS = 1 << (MAXO - MINO);

    bit             free_map [NODES];
    bit             slot_used [SLOTS];
    bit [ORD_W-1:0] slot_order [SLOTS];
    bit [7:0]       hdr;
    res_t           want_q [$];

    function automatic int node_of(int order, int pos);
        return ((1 << (MAXO - order)) - 1) + pos;
    endfunction

    function automatic res_t alloc_block(bit [16:0] req);
        res_t r;
        int total;
        int k;
        int j;
        int pos;
        bit found;
        r = '{ST_NOMEM, '0, '0};
        total = req + hdr;
        if (total == 0)
            total = 1;
        k = 0;
        while ((1 << k) < total)
            k++;
        if (k < MINO)
            k = MINO;
        if (k > MAXO)
            return r;
        found = 0;
        pos = 0;
        for (j = k; j <= MAXO; j++)
        begin
            for (pos = 0; pos < (1 << (MAXO - j)); pos++)
            begin
                if (free_map[node_of(j, pos)])
                begin
                    found = 1;
                    break;
                end
            end
            if (found)
                break;
        end
        if (!found)
            return r;
        free_map[node_of(j, pos)] = 0;
        while (j > k)
        begin
            j--;
            pos = pos << 1;
            free_map[node_of(j, pos + 1)] = 1;
        end
        slot_used[(pos << k) >> MINO] = 1;
        slot_order[(pos << k) >> MINO] = ORD_W'(k);
        r = '{ST_OK, ADDR_W'((pos << k) + hdr), ORD_W'(k)};
        return r;
    endfunction

    function automatic res_t free_block(bit [15:0] addr);
        res_t r;
        int off;
        int slot;
        int k;
        int pos;
        r = '{ST_BADFREE, '0, '0};
        if (addr < hdr)
            return r;
        off = addr - hdr;
        if (off >= (1 << MAXO) || (off % (1 << MINO)) != 0)
            return r;
        slot = off >> MINO;
        if (!slot_used[slot])
            return r;
        k = slot_order[slot];
        if (k < MINO || k > MAXO)
            return r;
        slot_used[slot] = 0;
        slot_order[slot] = 0;
        pos = off >> k;
        while (k < MAXO && free_map[node_of(k, pos ^ 1)])
        begin
            free_map[node_of(k, pos ^ 1)] = 0;
            pos = pos >> 1;
            k++;
        end
        free_map[node_of(k, pos)] = 1;
        r = '{ST_OK, '0, ORD_W'(k)};
        return r;
    endfunction

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t w;
        res_t got;
        if (!rst_n)
        begin
            foreach (free_map[i]) free_map[i] = 0;
            foreach (slot_used[i]) slot_used[i] = 0;
            foreach (slot_order[i]) slot_order[i] = 0;
            free_map[0] = 1;
            hdr = HDR_RESET;
            want_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                hdr = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (cmd_t'(s_axis_tuser) == CMD_ALLOC)
                    want_q.push_back(alloc_block(s_axis_tdata[16:0]));
                else
                    want_q.push_back(free_block(s_axis_tdata[32:17]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{st_t'(m_axis_tuser), m_axis_tdata[15:0], m_axis_tdata[20:16]};
                if (want_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    w = want_q.pop_front();
                    if (w !== got)
                    begin
                        errors++;
                        $display("%0t: expected st=%0d addr=%h ord=%0d, got st=%0d addr=%h ord=%0d",
                            $time, w.status, w.addr, w.order, got.status, got.addr, got.order);
                    end
                end
            end
        end
    end
endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import bdy_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          hold_out = 0;
    bit          calm = 0;
    logic [15:0] live [$];

    buddy_allocator dut (.*);
    buddy_checker chk (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 40000000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= !hold_out && (calm || $urandom_range(99) >= 12);

    task automatic send(cmd_t c, logic [16:0] req, logic [15:0] addr);
        if (!calm)
            while ($urandom_range(99) < 12)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1;
        s_axis_tuser <= c;
        s_axis_tdata <= {7'd0, addr, req};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_hdr(logic [7:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        live.delete();
    endtask

    task automatic watch_alloc();
        @(posedge clk);
        while (!(m_axis_tvalid && m_axis_tready))
            @(posedge clk);
        if (m_axis_tuser == ST_OK && m_axis_tdata[15:0] != 0)
            live.push_back(m_axis_tdata[15:0]);
    endtask

    task automatic random_item();
        int r;
        int i;
        r = $urandom_range(99);
        if (r < 50)
        begin
            if ($urandom_range(9) == 0)
                send(CMD_ALLOC, 17'($urandom), '0);
            else
                send(CMD_ALLOC, 17'($urandom_range(1 << $urandom_range(12))), '0);
            fork watch_alloc(); join_none
        end
        else if (r < 88 && live.size() > 0)
        begin
            i = $urandom_range(live.size() - 1);
            send(CMD_FREE, 17'($urandom), live[i]);
            live.delete(i);
        end
        else
            send(CMD_FREE, 17'($urandom), 16'($urandom));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(CMD_ALLOC, 17'd0, '0);
        send(CMD_ALLOC, 17'd8, '0);
        send(CMD_ALLOC, 17'd65536, '0);
        send(CMD_ALLOC, 17'h1FFFF, '0);
        send(CMD_ALLOC, 17'd65512, '0);
        send(CMD_FREE, '0, 16'd0);
        send(CMD_FREE, '0, 16'd24);
        send(CMD_FREE, '0, 16'd24);
        send(CMD_FREE, '0, 16'd57);
        send(CMD_FREE, '0, 16'hFFFF);
        send(CMD_FREE, '0, 16'd56);
        send(CMD_ALLOC, 17'd65512, '0);
        send(CMD_ALLOC, 17'd1, '0);
        send(CMD_FREE, '0, 16'd24);
        set_hdr(8'd0);
        send(CMD_ALLOC, 17'd0, '0);
        send(CMD_ALLOC, 17'd65536, '0);
        send(CMD_FREE, '0, 16'd0);
        send(CMD_FREE, '0, 16'd0);
        set_hdr(8'd255);
        send(CMD_ALLOC, 17'd1, '0);
        send(CMD_FREE, '0, 16'd255);
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 1)
                set_hdr(8'($urandom));
            if (ph == 2)
                set_hdr(8'd0);
            if (ph == 3)
                set_hdr(8'd255);
            calm = (ph == 1);
            if (ph == 2)
                fork
                    begin
                        hold_out = 1;
                        repeat (400) @(posedge clk);
                        hold_out = 0;
                    end
                join_none
            for (int n = 0; n < 270; n++)
                random_item();
            drain();
        end
        calm = 0;
        set_hdr(8'd24);
        for (int n = 0; n < 40; n++)
            random_item();
        drain();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
